[design/kole_pkg.sv]
// Package: sizes, operation and status codes, controller-datapath command and status types
package kole_pkg;

  localparam int unsigned Capacity = 64;
  localparam int unsigned KeyBits  = 64;
  localparam int unsigned SlotW    = $clog2(Capacity);
  localparam int unsigned LinkW    = SlotW + 1;

  localparam logic [LinkW-1:0] NoSlot = LinkW'(Capacity);

  typedef enum logic [2:0] {
    KIND_INS_HEAD   = 3'd0,
    KIND_INS_TAIL   = 3'd1,
    KIND_INS_AFTER  = 3'd2,
    KIND_INS_BEFORE = 3'd3,
    KIND_DELETE     = 3'd4,
    KIND_FIND       = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_DUPLICATE = 3'd2,
    ST_ABSENT    = 3'd3,
    ST_FULL      = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    WALK_KEY    = 2'd0,
    WALK_ANCHOR = 2'd1
  } walk_sel_e;

  typedef struct packed {
    logic      load;
    logic      walk_start;
    walk_sel_e walk_sel;
    logic      walk_step;
    logic      walk_end;
    logic      rd_cur;
    logic      ins_write;
    logic      ins_after_hit;
    logic      ins_at_head;
    logic      ins_link_prev;
    logic      del_unlink;
    logic      done;
    logic [2:0] status;
    logic      entry_valid;
  } kole_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       empty;
    logic       full;
    logic       cur_end;
    logic       cur_match;
    logic       steps_done;
    logic       any_free;
  } kole_sts_t;

endpackage

[design/keyed_ordered_list_engine.sv]
// Top level: keyed ordered list engine, controller plus datapath
//  channel  | handshake                 | payload
//  command  | start while !busy         | kind_i key_i anchor_key_i price_bits_i amount_i
//  result   | done_o, one cycle         | status_o entry_valid_o found_key_o
//           |                           | found_price_bits_o found_amount_o
// Insert before/after walks the list twice, once for the key and once for the
// anchor; each walk step waits on the registered read of the link store.
// Reset empties the list at once.
// The receiver cannot stall; busy holds off the next item.
module keyed_ordered_list_engine import kole_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [63:0] key_i,
  input  logic [63:0] anchor_key_i,
  input  logic [31:0] price_bits_i,
  input  logic [31:0] amount_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic        entry_valid_o,
  output logic [63:0] found_key_o,
  output logic [31:0] found_price_bits_o,
  output logic [31:0] found_amount_o
);

  kole_cmd_t cmd;
  kole_sts_t sts;

  kole_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .sts_i(sts), .busy_o(busy), .cmd_o(cmd));

  kole_datapath u_dp (
    .clk_i, .rst_ni, .kind_i, .key_i, .anchor_key_i, .price_bits_i, .amount_i,
    .cmd_i(cmd), .sts_o(sts), .done_o, .status_o, .entry_valid_o, .found_key_o,
    .found_price_bits_o, .found_amount_o);

endmodule

[design/kole_ram.sv]
// Generic single-port RAM with registered read
module kole_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

[design/kole_datapath.sv]
// Datapath: entry stores, link walker, free slot search, result registers
module kole_datapath import kole_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [2:0]      kind_i,
  input  logic [63:0]     key_i,
  input  logic [63:0]     anchor_key_i,
  input  logic [31:0]     price_bits_i,
  input  logic [31:0]     amount_i,
  input  kole_cmd_t       cmd_i,
  output kole_sts_t       sts_o,
  output logic            done_o,
  output logic [2:0]      status_o,
  output logic            entry_valid_o,
  output logic [63:0]     found_key_o,
  output logic [31:0]     found_price_bits_o,
  output logic [31:0]     found_amount_o
);

  logic [2:0]          kind_q;
  logic [KeyBits-1:0]  key_q, anchor_q, target_q;
  logic [31:0]         price_q, amount_q;
  logic [Capacity-1:0] used_q, used_d;
  logic [LinkW-1:0]    head_q, head_d;
  logic [LinkW-1:0]    len_q, len_d;
  logic [LinkW-1:0]    cur_q, cur_d, prev_q, prev_d, steps_q, steps_d;
  logic [LinkW-1:0]    hit_q, pred_q;
  logic [SlotW-1:0]    new_q;

  logic                we;
  logic [SlotW-1:0]    addr;
  logic [63:0]         name_wd, name_rd;
  logic [31:0]         price_wd, price_rd, amt_wd, amt_rd;
  logic [LinkW-1:0]    link_wd, link_rd;
  logic                name_we, link_we;

  logic [SlotW-1:0]    free_slot;
  logic                any_free;
  logic [KeyBits-1:0]  rd_key;

  always_comb begin
    free_slot = '0;
    any_free  = 1'b0;
    for (int i = Capacity - 1; i >= 0; i--) begin
      if (!used_q[i]) begin
        free_slot = SlotW'(i);
        any_free  = 1'b1;
      end
    end
  end

  assign rd_key = name_rd[KeyBits-1:0];

  always_comb begin
    name_we  = 1'b0;
    link_we  = 1'b0;
    addr     = cur_q[SlotW-1:0];
    name_wd  = 64'(key_q);
    price_wd = price_q;
    amt_wd   = amount_q;
    link_wd  = link_rd;
    used_d   = used_q;
    head_d   = head_q;
    len_d    = len_q;
    cur_d    = cur_q;
    prev_d   = prev_q;
    steps_d  = steps_q;
    if (cmd_i.walk_start) begin
      cur_d   = head_q;
      prev_d  = NoSlot;
      steps_d = '0;
    end else if (cmd_i.walk_step) begin
      prev_d  = cur_q;
      cur_d   = link_rd;
      steps_d = steps_q + 1'b1;
    end
    if (cmd_i.ins_write) begin
      // new slot: link to successor of the chosen predecessor
      name_we = 1'b1;
      link_we = 1'b1;
      addr    = free_slot;
      if (pred_q == NoSlot) begin
        link_wd = head_q;
        head_d  = {1'b0, free_slot};
      end else begin
        link_wd = link_rd;
      end
      used_d[free_slot] = 1'b1;
      len_d = len_q + 1'b1;
    end else if (cmd_i.ins_link_prev) begin
      link_we = (pred_q != NoSlot);
      addr    = pred_q[SlotW-1:0];
      link_wd = {1'b0, new_q};
    end else if (cmd_i.del_unlink) begin
      if (pred_q == NoSlot) begin
        head_d = link_rd;
      end else begin
        link_we = 1'b1;
        addr    = pred_q[SlotW-1:0];
        link_wd = link_rd;
      end
      used_d[hit_q[SlotW-1:0]] = 1'b0;
      len_d = len_q - 1'b1;
    end else if (cmd_i.rd_cur) begin
      addr = pred_q[SlotW-1:0];
    end
  end

  assign we = name_we;

  kole_ram #(.Width(64), .Depth(Capacity)) u_name (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(name_wd), .rdata_o(name_rd));
  kole_ram #(.Width(32), .Depth(Capacity)) u_price (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(price_wd), .rdata_o(price_rd));
  kole_ram #(.Width(32), .Depth(Capacity)) u_amt (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(amt_wd), .rdata_o(amt_rd));
  kole_ram #(.Width(LinkW), .Depth(Capacity)) u_link (
    .clk_i, .we_i(link_we), .addr_i(addr), .wdata_i(link_wd), .rdata_o(link_rd));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q        <= '0;
      head_q        <= NoSlot;
      len_q         <= '0;
      cur_q         <= NoSlot;
      prev_q        <= NoSlot;
      steps_q       <= '0;
      hit_q         <= NoSlot;
      pred_q        <= NoSlot;
      done_o        <= 1'b0;
      status_o      <= 3'(ST_OK);
      entry_valid_o <= 1'b0;
    end else begin
      used_q  <= used_d;
      head_q  <= head_d;
      len_q   <= len_d;
      cur_q   <= cur_d;
      prev_q  <= prev_d;
      steps_q <= steps_d;
      if (cmd_i.walk_start) begin
        hit_q  <= NoSlot;
        pred_q <= NoSlot;
      end else if (cmd_i.walk_end) begin
        hit_q  <= sts_o.cur_match ? cur_q : NoSlot;
        pred_q <= prev_q;
      end else if (cmd_i.ins_after_hit) begin
        pred_q <= hit_q;
      end else if (cmd_i.ins_at_head) begin
        pred_q <= NoSlot;
      end
      done_o        <= cmd_i.done;
      status_o      <= cmd_i.status;
      entry_valid_o <= cmd_i.entry_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q   <= kind_i;
      key_q    <= key_i[KeyBits-1:0];
      anchor_q <= anchor_key_i[KeyBits-1:0];
      price_q  <= price_bits_i;
      amount_q <= amount_i;
    end
    if (cmd_i.walk_start) begin
      target_q <= (cmd_i.walk_sel == WALK_ANCHOR) ? anchor_q : key_q;
    end
    if (cmd_i.ins_write) begin
      new_q <= free_slot;
    end
    if (cmd_i.done) begin
      found_key_o        <= cmd_i.entry_valid ? name_rd : 64'd0;
      found_price_bits_o <= cmd_i.entry_valid ? price_rd : 32'd0;
      found_amount_o     <= cmd_i.entry_valid ? amt_rd : 32'd0;
    end
  end

  assign sts_o.kind       = kind_q;
  assign sts_o.empty      = (head_q == NoSlot);
  assign sts_o.full       = (len_q == NoSlot);
  assign sts_o.cur_end    = (cur_q == NoSlot);
  assign sts_o.cur_match  = (cur_q != NoSlot) && (rd_key == target_q);
  assign sts_o.steps_done = (steps_q == NoSlot);
  assign sts_o.any_free   = any_free;

endmodule

[design/kole_ctrl.sv]
// Controller: sequences walks, inserts, deletes and finds for one item
module kole_ctrl import kole_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  kole_sts_t sts_i,
  output logic      busy_o,
  output kole_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WAIT, S_CHECK, S_DUP_DONE, S_ANC_START, S_ANC_WAIT,
    S_ANC_CHECK, S_PLACE_RD, S_PLACE_WR, S_PLACE_LINK, S_DEL_RD, S_DEL_WR, S_FIND_RD,
    S_FIND_OUT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.kind > 3'(KIND_FIND)) begin
          cmd_o.done   = 1'b1;
          cmd_o.status = 3'(ST_OK);
          state_d      = S_IDLE;
        end else if (sts_i.empty && sts_i.kind != 3'(KIND_INS_HEAD)
                     && sts_i.kind != 3'(KIND_INS_TAIL)) begin
          cmd_o.done   = 1'b1;
          cmd_o.status = 3'(ST_EMPTY);
          state_d      = S_IDLE;
        end else begin
          cmd_o.walk_start = 1'b1;
          cmd_o.walk_sel   = WALK_KEY;
          state_d          = S_WAIT;
        end
      end
      S_WAIT: state_d = S_CHECK;
      S_CHECK: begin
        if (!(sts_i.cur_match || sts_i.cur_end || sts_i.steps_done)) begin
          cmd_o.walk_step = 1'b1;
          state_d         = S_WAIT;
        end else begin
          cmd_o.walk_end = 1'b1;
          state_d        = S_DUP_DONE;
        end
      end
      S_DUP_DONE: begin
        // hit and predecessor now registered; cur still addresses the hit
        unique case (sts_i.kind)
          3'(KIND_INS_HEAD), 3'(KIND_INS_TAIL): begin
            if (sts_i.cur_match) begin
              cmd_o.done = 1'b1; cmd_o.status = 3'(ST_DUPLICATE); state_d = S_IDLE;
            end else if (sts_i.full) begin
              cmd_o.done = 1'b1; cmd_o.status = 3'(ST_FULL); state_d = S_IDLE;
            end else if (sts_i.kind == 3'(KIND_INS_HEAD)) begin
              cmd_o.ins_at_head = 1'b1;
              state_d = S_PLACE_WR;
            end else begin
              state_d = S_PLACE_RD;
            end
          end
          3'(KIND_INS_AFTER), 3'(KIND_INS_BEFORE): begin
            if (sts_i.cur_match) begin
              cmd_o.done = 1'b1; cmd_o.status = 3'(ST_DUPLICATE); state_d = S_IDLE;
            end else begin
              state_d = S_ANC_START;
            end
          end
          3'(KIND_DELETE): begin
            if (!sts_i.cur_match) begin
              cmd_o.done = 1'b1; cmd_o.status = 3'(ST_ABSENT); state_d = S_IDLE;
            end else begin
              state_d = S_DEL_RD;
            end
          end
          default: begin
            if (!sts_i.cur_match) begin
              cmd_o.done = 1'b1; cmd_o.status = 3'(ST_ABSENT); state_d = S_IDLE;
            end else begin
              cmd_o.done = 1'b1; cmd_o.status = 3'(ST_OK);
              cmd_o.entry_valid = 1'b1; state_d = S_IDLE;
            end
          end
        endcase
      end
      S_ANC_START: begin
        cmd_o.walk_start = 1'b1;
        cmd_o.walk_sel   = WALK_ANCHOR;
        state_d          = S_ANC_WAIT;
      end
      S_ANC_WAIT: state_d = S_ANC_CHECK;
      S_ANC_CHECK: begin
        if (!(sts_i.cur_match || sts_i.cur_end || sts_i.steps_done)) begin
          cmd_o.walk_step = 1'b1;
          state_d         = S_ANC_WAIT;
        end else begin
          cmd_o.walk_end = 1'b1;
          if (!sts_i.cur_match) begin
            cmd_o.done = 1'b1; cmd_o.status = 3'(ST_ABSENT); state_d = S_IDLE;
          end else if (sts_i.full) begin
            cmd_o.done = 1'b1; cmd_o.status = 3'(ST_FULL); state_d = S_IDLE;
          end else begin
            state_d = S_FIND_RD;
          end
        end
      end
      S_FIND_RD: begin
        // anchor result registered; pick predecessor for the new entry
        cmd_o.ins_after_hit = (sts_i.kind == 3'(KIND_INS_AFTER));
        state_d = S_PLACE_RD;
      end
      S_PLACE_RD: begin
        cmd_o.rd_cur = 1'b1;
        state_d      = S_PLACE_WR;
      end
      S_PLACE_WR: begin
        cmd_o.ins_write = 1'b1;
        state_d         = S_PLACE_LINK;
      end
      S_PLACE_LINK: begin
        cmd_o.ins_link_prev = 1'b1;
        state_d             = S_FIND_OUT;
      end
      S_FIND_OUT: begin
        cmd_o.done   = 1'b1;
        cmd_o.status = 3'(ST_OK);
        state_d      = S_IDLE;
      end
      S_DEL_RD: begin
        state_d = S_DEL_WR;
      end
      S_DEL_WR: begin
        cmd_o.del_unlink = 1'b1;
        state_d          = S_FIND_OUT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule
